>>> hdl/uks_pkg.sv
package uks_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_NOTPOS = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming word
    logic scan_step;  // issue the next key read of the duplicate search
    logic pop_read;   // read the top entry
    logic finish;     // resolve the item and load the output register
  } uks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_pop;     // action of the word on the input port
    logic scan_done;  // every stored key has been compared
    logic out_free;   // output register can take a result this cycle
  } uks_sts_t;

endpackage

>>> hdl/uks_ctrl.sv
module uks_ctrl
  import uks_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  uks_sts_t sts,
  output uks_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.scan_step = (state == S_SCAN);
    cmd.pop_read  = (state == S_POP_RD);
    cmd.finish    = (state == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= sts.in_pop ? S_POP_RD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_POP_RD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/uks_dp.sv
module uks_dp
  import uks_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uks_cmd_t              cmd,
  output uks_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_action,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [KEY_W-1:0] key_mem [STACK_DEPTH];
  logic [VAL_W-1:0] val_mem [STACK_DEPTH];

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             pop_r;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_next;
  logic [CW-1:0]    idx;
  logic             cmp_valid;
  logic             dup;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    top_idx;
  logic             scan_more;

  logic [KEY_W-1:0] res_key;
  logic [VAL_W-1:0] res_val;
  status_t          res_status;
  logic             do_write;
  logic [31:0]      fill_ext;

  assign top_idx   = fill - CW'(1);
  assign scan_more = (idx != fill);
  assign rd_addr   = cmd.pop_read ? top_idx[AW-1:0] : idx[AW-1:0];

  assign sts.in_pop    = in_action;
  assign sts.scan_done = !scan_more && !cmp_valid;
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    res_key    = '0;
    res_val    = '0;
    res_status = ST_OK;
    do_write   = 1'b0;
    fill_next  = fill;
    if (pop_r == ACT_POP) begin
      if (fill == '0) begin
        res_status = ST_EMPTY;
      end else begin
        fill_next = top_idx;
        res_key   = rd_key;
        res_val   = rd_val;
      end
    end else begin
      priority if (dup) begin
        res_status = ST_DUP;
      end else if (key_r == '0 || key_r[KEY_W-1]) begin
        res_status = ST_NOTPOS;
      end else if (fill == CW'(STACK_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        do_write  = 1'b1;
        fill_next = fill + CW'(1);
      end
    end
  end

  assign fill_ext = 32'(fill_next);

  // Entry storage: one write port, one registered read port. The read data holds
  // while the result waits for the output register.
  always_ff @(posedge clk) begin
    if (cmd.finish && do_write) begin
      key_mem[fill[AW-1:0]] <= key_r;
      val_mem[fill[AW-1:0]] <= val_r;
    end
    if (cmd.scan_step || cmd.pop_read) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_data[KEY_W-1:0];
      val_r <= in_data[KEY_W +: VAL_W];
      pop_r <= in_action;
    end
    if (cmd.finish) begin
      out_data   <= {3'b000, fill_ext[COUNT_W-1:0], res_val, res_key};
      out_status <= res_status;
    end
  end

  // The search issues one read per cycle and compares the previous read's data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      dup       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx       <= '0;
        cmp_valid <= 1'b0;
        dup       <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          cmp_valid <= scan_more;
          if (scan_more) begin
            idx <= idx + CW'(1);
          end
        end
        if (cmp_valid && (rd_key == key_r)) begin
          dup <= 1'b1;
        end
      end
      if (cmd.finish) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/unique_key_stack.sv
// Channel  Direction  Word fields (lowest bit up)
// s_*      in         tuser: action; tdata: key[31:0], value[63:32]
// m_*      out        tuser: status; tdata: out_key[31:0], out_value[63:32],
//                     entry_count[68:64], zero[71:69]
//
// A pop reads the top entry and then loads the output register; a push first runs the
// duplicate search, which reads one stored key per cycle and compares each read's data
// once it is registered, then resolves the item and loads the output register. Either
// waits to load while the output register still holds a result that is not taken.
// Reset is synchronous and empties the stack; no clearing pass is needed.
// A word is accepted while a result waits; a stalled output holds the next result in the finish state and blocks input.
module unique_key_stack
  import uks_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key, value
  input  logic [0:0]            s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_key, out_value, entry_count
  output logic [STATUS_W-1:0]   m_tuser    // status
);

  uks_cmd_t cmd;
  uks_sts_t sts;

  uks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uks_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (s_tdata),
    .in_action  (s_tuser[0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (m_tuser)
  );

endmodule
